// ===== src/csb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_pkg
// Shared widths, command codes, register map and pipeline types for the
// raised-cosine seam blender.
// ----------------------------------------------------------------------------
package csb_pkg;

  // sample and field widths
  localparam int H_W    = 24;
  localparam int CMD_W  = 2;
  localparam int POS_W  = 6;
  localparam int STEP_W = 17;
  localparam int W_W    = 17;

  // blend geometry
  localparam int MAX_OVERLAP    = 64;
  localparam int COS_TABLE_BITS = 10;
  localparam int PHASE_ONE      = 65536;
  localparam int IDX_W          = COS_TABLE_BITS + 1;
  localparam int ROM_DEPTH      = (1 << COS_TABLE_BITS) + 1;

  // command codes; any code with bit 1 set is a corner blend
  localparam logic [CMD_W-1:0] CMD_HORZ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_VERT = 2'd1;

  // pipeline depth: index, rom, weights, products, pair sums, final sum
  localparam int NSTG = 6;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'b0;
  localparam logic [STEP_W-1:0]    PHASE_STEP_RST = 17'd4369;

  typedef struct packed {
    logic signed [H_W-1:0] a;
    logic signed [H_W-1:0] b;
    logic signed [H_W-1:0] c;
    logic signed [H_W-1:0] d;
  } samples_t;

endpackage

// ===== src/csb_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_index
// Stage 1: turns row and column positions into cosine ROM indexes through
// the configured phase step, and routes samples by blend mode.
// ----------------------------------------------------------------------------
module csb_index
  import csb_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [POS_W-1:0]  row_pos,
  input  logic [POS_W-1:0]  col_pos,
  input  logic [STEP_W-1:0] phase_step,
  input  samples_t          samp,
  output logic [IDX_W-1:0]  idx_row_r,
  output logic [IDX_W-1:0]  idx_col_r,
  output samples_t          samp_r
);

  localparam int PHASE_W    = POS_W + STEP_W;
  localparam int ROUND_HALF = 2 ** (15 - COS_TABLE_BITS);

  logic [IDX_W-1:0] row_idx;
  logic [IDX_W-1:0] col_idx;
  logic [IDX_W-1:0] idx_row_nxt;
  logic [IDX_W-1:0] idx_col_nxt;
  samples_t         samp_nxt;

  function automatic logic [IDX_W-1:0] pos_to_index(input logic [POS_W-1:0] pos,
                                                    input logic [STEP_W-1:0] step);
    logic [POS_W-1:0]   p;
    logic [PHASE_W-1:0] phase;
    logic [16:0]        rnd;
    logic [IDX_W-1:0]   idx;
    p = (32'(pos) > 32'(MAX_OVERLAP - 1)) ? POS_W'(MAX_OVERLAP - 1) : pos;
    phase = PHASE_W'(p) * PHASE_W'(step);
    rnd = {1'b0, phase[15:0]} + 17'(ROUND_HALF);
    // saturated phase reads the last entry, which is exactly one
    if (phase >= PHASE_W'(PHASE_ONE)) begin
      idx = IDX_W'(ROM_DEPTH - 1);
    end else begin
      idx = rnd[16:16-COS_TABLE_BITS];
    end
    return idx;
  endfunction

  always_comb begin
    row_idx     = pos_to_index(row_pos, phase_step);
    col_idx     = pos_to_index(col_pos, phase_step);
    samp_nxt    = samp;
    idx_row_nxt = row_idx;
    idx_col_nxt = col_idx;
    // two-sample modes reuse the corner blend with one weight at zero
    case (cmd)
      CMD_HORZ: begin
        idx_row_nxt = '0;
        samp_nxt.c  = samp.b;
      end
      CMD_VERT: begin
        idx_col_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_row_r <= idx_row_nxt;
      idx_col_r <= idx_col_nxt;
      samp_r    <= samp_nxt;
    end
  end

endmodule

// ===== src/csb_weight_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_weight_rom
// Stage 2: raised-cosine weight ROM with two registered read ports, one for
// the row weight and one for the column weight. Entries are Q1.16.
// ----------------------------------------------------------------------------
module csb_weight_rom
  import csb_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] idx_row,
  input  logic [IDX_W-1:0] idx_col,
  input  samples_t         samp,
  output logic [W_W-1:0]   wr_r,
  output logic [W_W-1:0]   wc_r,
  output samples_t         samp_r
);

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] SIN_ONE     = 64'd1 << 30;
  localparam logic [63:0] SQ_ROUND    = 64'd1 << 43;

  typedef logic [W_W-1:0] rom_arr_t [ROM_DEPTH];

  // sin^2 of the quarter-wave angle, from a Taylor series through x^15
  function automatic rom_arr_t build_rom();
    rom_arr_t    tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] w;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      if (i == ROM_DEPTH - 1) begin
        tbl[i] = W_W'(PHASE_ONE);
      end else begin
        x    = (PI_HALF_Q30 * 64'(i)) >> COS_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = (term > sum) ? 64'd0 : sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = (term > sum) ? 64'd0 : sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = (term > sum) ? 64'd0 : sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = (term > sum) ? 64'd0 : sum - term;
        if (sum > SIN_ONE) begin
          sum = SIN_ONE;
        end
        w = (sum * sum + SQ_ROUND) >> 44;
        if (w > 64'(PHASE_ONE)) begin
          w = 64'(PHASE_ONE);
        end
        tbl[i] = W_W'(w);
      end
    end
    return tbl;
  endfunction

  localparam rom_arr_t WEIGHT_ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      wr_r   <= WEIGHT_ROM[idx_row];
      wc_r   <= WEIGHT_ROM[idx_col];
      samp_r <= samp;
    end
  end

endmodule

// ===== src/csb_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_mac
// Stages 3 to 6: four Q1.32 corner weights, four weighted samples, two pair
// sums, then the final sum with rounding and 24-bit saturation.
// ----------------------------------------------------------------------------
module csb_mac
  import csb_pkg::*;
(
  input  logic                  clk,
  input  logic [3:0]            en,
  input  logic [W_W-1:0]        wr,
  input  logic [W_W-1:0]        wc,
  input  samples_t              samp,
  output logic signed [H_W-1:0] result_r
);

  localparam int QW_W  = 2 * W_W - 1;
  localparam int ACC_W = QW_W + H_W + 1;
  localparam int RES_W = ACC_W - 32;
  localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(64'd1 << 31);

  logic [W_W-1:0]            nr;
  logic [W_W-1:0]            nc;
  logic [QW_W-1:0]           q_nxt   [4];
  logic [QW_W-1:0]           q_r     [4];
  samples_t                  samp_q_r;
  logic signed [H_W-1:0]     lane_h  [4];
  logic signed [ACC_W-1:0]   prod_r  [4];
  logic signed [ACC_W-1:0]   s01_r;
  logic signed [ACC_W-1:0]   s23_r;
  logic signed [ACC_W-1:0]   total;
  logic signed [RES_W-1:0]   res;
  logic [RES_W-H_W:0]        res_top;
  logic signed [H_W-1:0]     result_nxt;

  // stage 3: complementary weights and their products
  always_comb begin
    nr       = W_W'(PHASE_ONE) - wr;
    nc       = W_W'(PHASE_ONE) - wc;
    q_nxt[0] = QW_W'(nr * nc);
    q_nxt[1] = QW_W'(wr * nc);
    q_nxt[2] = QW_W'(nr * wc);
    q_nxt[3] = QW_W'(wr * wc);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q_r      <= q_nxt;
      samp_q_r <= samp;
    end
  end

  // stage 4: one multiplier per lane
  always_comb begin
    lane_h[0] = samp_q_r.a;
    lane_h[1] = samp_q_r.b;
    lane_h[2] = samp_q_r.c;
    lane_h[3] = samp_q_r.d;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= ACC_W'($signed({1'b0, q_r[k]})) * ACC_W'(lane_h[k]);
      end
    end
  end

  // stage 5: pair sums
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s01_r <= prod_r[0] + prod_r[1];
      s23_r <= prod_r[2] + prod_r[3];
    end
  end

  // stage 6: round to nearest (ties up), floor shift, saturate
  always_comb begin
    total   = s01_r + s23_r + ACC_ROUND;
    res     = total[ACC_W-1:32];
    res_top = res[RES_W-1:H_W-1];
    if ((&res_top) || !(|res_top)) begin
      result_nxt = res[H_W-1:0];
    end else if (res[RES_W-1]) begin
      result_nxt = {1'b1, {(H_W-1){1'b0}}};
    end else begin
      result_nxt = {1'b0, {(H_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      result_r <= result_nxt;
    end
  end

endmodule

// ===== src/cosine_seam_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_seam_blend
// Raised-cosine blend of terrain height samples across a patch seam:
// horizontal, vertical and four-patch corner modes.
//
//   channel  handshake                  payload
//   in       in_valid / in_stall        in_cmd, in_row_pos, in_col_pos,
//                                       in_height_a .. in_height_d
//   out      out_valid / out_stall      out_blended_height
//   cfg      psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// Six register stages; one beat is taken per cycle while the output is not stalled.
// The stage count is set by the weight ROM read and the two multiplier ranks.
// Each stage holds its own valid bit and refills whenever it is empty, so a
// stalled output only backs up stages that hold a beat.
// Reset clears the valid bits and loads phase_step with 4369.
// ----------------------------------------------------------------------------
module cosine_seam_blend
  import csb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [POS_W-1:0]      in_row_pos,
  input  logic [POS_W-1:0]      in_col_pos,
  input  logic signed [H_W-1:0] in_height_a,
  input  logic signed [H_W-1:0] in_height_b,
  input  logic signed [H_W-1:0] in_height_c,
  input  logic signed [H_W-1:0] in_height_d,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [H_W-1:0] out_blended_height,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [STEP_W-1:0]    phase_step_r;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  logic [NSTG-1:0]      v_r;
  logic [NSTG-1:0]      v_nxt;
  logic [NSTG-1:0]      adv;

  samples_t             samp_in;
  samples_t             samp_s1;
  samples_t             samp_s2;
  logic [IDX_W-1:0]     idx_row_s1;
  logic [IDX_W-1:0]     idx_col_s1;
  logic [W_W-1:0]       wr_s2;
  logic [W_W-1:0]       wc_s2;

  // configuration register
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST;
    end else if (cfg_wr && (reg_idx == REG_PHASE_STEP)) begin
      phase_step_r <= pwdata[STEP_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PHASE_STEP: prdata = CFG_DATA_W'(phase_step_r);
      default:        prdata = '0;
    endcase
  end

  // stage advance: a stage loads when it is empty or its successor loads
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int s = NSTG - 2; s >= 0; s--) begin
      adv[s] = !v_r[s] || adv[s+1];
    end
  end

  assign v_nxt = {v_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (adv[s]) begin
          v_r[s] <= v_nxt[s];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v_r[NSTG-1];

  always_comb begin
    samp_in.a = in_height_a;
    samp_in.b = in_height_b;
    samp_in.c = in_height_c;
    samp_in.d = in_height_d;
  end

  csb_index u_index (
    .clk        (clk),
    .en         (adv[0]),
    .cmd        (in_cmd),
    .row_pos    (in_row_pos),
    .col_pos    (in_col_pos),
    .phase_step (phase_step_r),
    .samp       (samp_in),
    .idx_row_r  (idx_row_s1),
    .idx_col_r  (idx_col_s1),
    .samp_r     (samp_s1)
  );

  csb_weight_rom u_rom (
    .clk     (clk),
    .en      (adv[1]),
    .idx_row (idx_row_s1),
    .idx_col (idx_col_s1),
    .samp    (samp_s1),
    .wr_r    (wr_s2),
    .wc_r    (wc_s2),
    .samp_r  (samp_s2)
  );

  csb_mac u_mac (
    .clk      (clk),
    .en       (adv[NSTG-1:2]),
    .wr       (wr_s2),
    .wc       (wc_s2),
    .samp     (samp_s2),
    .result_r (out_blended_height)
  );

endmodule

// ===== tb/cosine_seam_blend_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_seam_blend_test
// Self-checking bench for the raised-cosine seam blender. A queue of blend
// requests feeds a clocked driver; a clocked monitor compares every result
// beat with a local prediction built from its own weight table. The run
// walks several phase_step settings, extremes included, and idles both sides.
// ----------------------------------------------------------------------------
module cosine_seam_blend_test;
  import csb_pkg::*;

  localparam logic [CMD_W-1:0]      CMD_CORNER      = 2'd2;
  localparam logic [CMD_W-1:0]      CMD_CORNER_ALT  = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] PHASE_STEP_ADDR = {REG_PHASE_STEP, 2'b00};
  localparam logic signed [H_W-1:0] H_MAX           = 24'sh7FFFFF;
  localparam logic signed [H_W-1:0] H_MIN           = 24'sh800000;
  localparam longint unsigned       PI_HALF_Q30     = 64'd1686629713;
  localparam int                    HOLD_CYCLES     = 300;
  localparam int                    IDLE_LIMIT      = 2000;
  localparam int                    PHASE_BEATS     = 190;

  typedef struct {
    logic [CMD_W-1:0]      cmd;
    logic [POS_W-1:0]      row;
    logic [POS_W-1:0]      col;
    logic signed [H_W-1:0] a;
    logic signed [H_W-1:0] b;
    logic signed [H_W-1:0] c;
    logic signed [H_W-1:0] d;
  } seam_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd = '0;
  logic [POS_W-1:0]      in_row_pos = '0;
  logic [POS_W-1:0]      in_col_pos = '0;
  logic signed [H_W-1:0] in_height_a = '0;
  logic signed [H_W-1:0] in_height_b = '0;
  logic signed [H_W-1:0] in_height_c = '0;
  logic signed [H_W-1:0] in_height_d = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [H_W-1:0] out_blended_height;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  cosine_seam_blend dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_row_pos(in_row_pos), .in_col_pos(in_col_pos),
    .in_height_a(in_height_a), .in_height_b(in_height_b),
    .in_height_c(in_height_c), .in_height_d(in_height_d),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_blended_height(out_blended_height),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  seam_beat_t            beat_q[$];
  logic signed [H_W-1:0] height_q[$];
  seam_beat_t            cur_beat;
  longint unsigned       cos_rom [0:ROM_DEPTH-1];
  logic [STEP_W-1:0]     phase_step_model = PHASE_STEP_RST;
  int                    err_count = 0;
  int                    beats_sent = 0;
  int                    results_seen = 0;
  int                    gap_left = 0;
  bit                    in_burst = 1'b0;
  int                    stall_left = 0;
  int                    hold_left = 0;
  bit                    hold_done = 1'b0;
  bit                    out_free = 1'b0;
  int                    stall_tick = 0;
  int                    idle_cycles = 0;

  // Q1.16 raised-cosine weight as sin^2 of the Q2.30 half-angle
  function automatic longint unsigned raised_cos_entry(int unsigned i);
    longint unsigned x, x2, term, sin_acc, w;
    if (i >= (1 << COS_TABLE_BITS)) return 64'(PHASE_ONE);
    x = (PI_HALF_Q30 * i) >> COS_TABLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    sin_acc = x;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sin_acc = (term > sin_acc) ? 64'd0 : sin_acc - term;
      else sin_acc = sin_acc + term;
    end
    if (sin_acc > (64'd1 << 30)) sin_acc = 64'd1 << 30;
    w = (sin_acc * sin_acc + (64'd1 << 43)) >> 44;
    if (w > PHASE_ONE) w = 64'(PHASE_ONE);
    return w;
  endfunction

  function automatic longint seam_weight(logic [POS_W-1:0] pos);
    longint unsigned p, phase;
    p = 64'(pos);
    if (p > MAX_OVERLAP - 1) p = 64'(MAX_OVERLAP - 1);
    phase = p * phase_step_model;
    if (phase >= PHASE_ONE) return longint'(PHASE_ONE);
    return cos_rom[(phase + (64'd1 << (15 - COS_TABLE_BITS))) >> (16 - COS_TABLE_BITS)];
  endfunction

  function automatic logic signed [H_W-1:0] blend_height(seam_beat_t t);
    longint one, wr, wc, w, acc, res;
    one = longint'(PHASE_ONE);
    if (t.cmd[1]) begin
      wr = seam_weight(t.row);
      wc = seam_weight(t.col);
      acc = (one - wr) * (one - wc) * longint'(t.a) + wr * (one - wc) * longint'(t.b)
          + (one - wr) * wc * longint'(t.c) + wr * wc * longint'(t.d);
      res = (acc + (longint'(1) <<< 31)) >>> 32;
    end else begin
      w = seam_weight(t.cmd == CMD_HORZ ? t.col : t.row);
      acc = w * longint'(t.b) + (one - w) * longint'(t.a);
      res = (acc + (longint'(1) <<< 15)) >>> 16;
    end
    if (res > longint'(H_MAX)) res = longint'(H_MAX);
    if (res < longint'(H_MIN)) res = longint'(H_MIN);
    return res[H_W-1:0];
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 19) < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // first position whose phase reaches one, 64 if none does
  function automatic int unsigned saturating_pos();
    int unsigned p;
    if (phase_step_model == 0) return MAX_OVERLAP;
    p = (PHASE_ONE + phase_step_model - 1) / phase_step_model;
    return (p > MAX_OVERLAP) ? MAX_OVERLAP : p;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int unsigned p;
    case ($urandom_range(0, 9))
      0: p = 0;
      1: p = MAX_OVERLAP - 1;
      2: p = saturating_pos() + $urandom_range(0, 2) - 1;
      default: p = $urandom_range(0, MAX_OVERLAP - 1);
    endcase
    if (p > MAX_OVERLAP - 1) p = $urandom_range(0, MAX_OVERLAP - 1);
    return p[POS_W-1:0];
  endfunction

  function automatic logic signed [H_W-1:0] pick_height();
    logic [11:0] low_bits;
    low_bits = 12'($urandom);
    case ($urandom_range(0, 9))
      0: return H_MAX;
      1: return H_MIN;
      2, 3: return {{(H_W - 12){low_bits[11]}}, low_bits};
      default: return H_W'($urandom);
    endcase
  endfunction

  function automatic seam_beat_t random_beat();
    seam_beat_t t;
    t.cmd = CMD_W'($urandom_range(0, 3));
    t.row = pick_pos();
    t.col = pick_pos();
    t.a = pick_height();
    t.b = pick_height();
    t.c = pick_height();
    t.d = pick_height();
    return t;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_count < 40) $display("%0t %s: got %0h, expected %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic add_beat(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] row,
                          logic [POS_W-1:0] col, logic signed [H_W-1:0] a,
                          logic signed [H_W-1:0] b, logic signed [H_W-1:0] c,
                          logic signed [H_W-1:0] d);
    seam_beat_t t;
    t.cmd = cmd; t.row = row; t.col = col;
    t.a = a; t.b = b; t.c = c; t.d = d;
    beat_q = {beat_q, t};
  endtask

  task automatic program_phase_step(logic [STEP_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PHASE_STEP_ADDR;
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    phase_step_model = value;
    // turn straight into a readback setup
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[STEP_W-1:0] !== value)
      report_mismatch("phase_step readback", prdata, CFG_DATA_W'(value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (beat_q.size() != 0 || in_valid || height_q.size() != 0) @(negedge clk);
  endtask

  // driver: present queued beats, hold while stalled, idle between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        height_q = {height_q, blend_height(cur_beat)};
        beats_sent++;
        if (beats_sent % 64 == 0) in_burst = ($urandom_range(0, 2) == 0);
        gap_left = (in_burst || $urandom_range(0, 1) == 0) ? 0 : idle_len();
      end
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (beat_q.size() > 0) begin
        cur_beat = beat_q.pop_front();
        in_valid <= 1'b1;
        in_cmd <= cur_beat.cmd;
        in_row_pos <= cur_beat.row;
        in_col_pos <= cur_beat.col;
        in_height_a <= cur_beat.a;
        in_height_b <= cur_beat.b;
        in_height_c <= cur_beat.c;
        in_height_d <= cur_beat.d;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random idling, one long hold while the sender keeps going
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen > 300 && beat_q.size() > 60) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_tick++;
      if (stall_tick % 97 == 0) out_free = ($urandom_range(0, 2) == 0);
      if (!out_free && $urandom_range(0, 3) == 0) begin
        stall_left = int'(idle_len()) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest predicted height
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (height_q.size() == 0)
        report_mismatch("unexpected result", 32'(out_blended_height), 32'd0);
      else if (out_blended_height !== height_q[0])
        report_mismatch("blended_height", 32'(out_blended_height), 32'(height_q[0]));
      if (height_q.size() != 0) void'(height_q.pop_front());
      results_seen++;
    end
  end

  // watchdog: too long with no beat and no register access
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("cosine_seam_blend_test NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [STEP_W-1:0] step_plan[$];
    for (int i = 0; i < ROM_DEPTH; i++) cos_rom[i] = raised_cos_entry(i);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default step (overlap 16), position 15 lands just under one
    add_beat(CMD_HORZ, 6'd41, 6'd0, H_MAX, H_MIN, 24'sd5, -24'sd5);
    add_beat(CMD_HORZ, 6'd3, 6'd63, H_MIN, H_MAX, H_MAX, H_MIN);
    add_beat(CMD_HORZ, 6'd0, 6'd7, 24'sd100, -24'sd100, 24'sd0, 24'sd0);
    add_beat(CMD_HORZ, 6'd63, 6'd15, 24'sd1, 24'sd0, H_MAX, H_MAX);
    add_beat(CMD_HORZ, 6'd20, 6'd16, H_MIN, H_MIN, H_MAX, H_MAX);
    add_beat(CMD_HORZ, 6'd9, 6'd1, 24'sd0, 24'sd1, 24'sd3, 24'sd3);
    add_beat(CMD_VERT, 6'd0, 6'd63, H_MAX, H_MIN, 24'sd7, 24'sd7);
    add_beat(CMD_VERT, 6'd63, 6'd0, H_MIN, H_MAX, H_MIN, H_MIN);
    add_beat(CMD_VERT, 6'd8, 6'd33, -24'sd1, 24'sd1, H_MAX, H_MIN);
    add_beat(CMD_VERT, 6'd16, 6'd5, H_MAX, H_MAX, H_MIN, H_MIN);
    add_beat(CMD_VERT, 6'd14, 6'd63, 24'sd0, -24'sd1, 24'sd0, 24'sd0);
    add_beat(CMD_CORNER, 6'd0, 6'd0, H_MAX, H_MIN, H_MIN, H_MIN);
    add_beat(CMD_CORNER, 6'd63, 6'd63, H_MAX, H_MAX, H_MAX, H_MIN);
    add_beat(CMD_CORNER, 6'd5, 6'd10, H_MAX, H_MIN, H_MIN, H_MAX);
    add_beat(CMD_CORNER, 6'd63, 6'd0, H_MIN, H_MAX, H_MIN, H_MIN);
    add_beat(CMD_CORNER, 6'd0, 6'd63, H_MIN, H_MIN, H_MAX, H_MIN);
    add_beat(CMD_CORNER, 6'd7, 6'd8, H_MAX, H_MAX, H_MAX, H_MAX);
    add_beat(CMD_CORNER, 6'd7, 6'd8, H_MIN, H_MIN, H_MIN, H_MIN);
    add_beat(CMD_CORNER, 6'd3, 6'd12, 24'sd1, -24'sd1, 24'sd1, -24'sd1);
    add_beat(CMD_CORNER_ALT, 6'd3, 6'd12, 24'sd1000, -24'sd2000, 24'sd3000, -24'sd4000);
    add_beat(CMD_CORNER_ALT, 6'd63, 6'd63, H_MIN, H_MIN, H_MIN, H_MAX);
    add_beat(CMD_CORNER_ALT, 6'd0, 6'd0, H_MIN, H_MAX, H_MAX, H_MAX);
    wait_drained();
    repeat (PHASE_BEATS) beat_q = {beat_q, random_beat()};
    wait_drained();

    // zero, smallest, exactly one, register max, then usual overlaps
    step_plan = '{17'd0, 17'd1, 17'd65536, 17'd131071, 17'd1040, 17'd2185,
                  17'd32768, 17'd13107};
    step_plan = {step_plan, STEP_W'($urandom_range(1, 65536))};
    foreach (step_plan[i]) begin
      program_phase_step(step_plan[i]);
      // the zero step and the register max get a few directed beats too
      if (i == 0 || i == 3) begin
        add_beat(CMD_HORZ, 6'd0, 6'd63, H_MAX, H_MIN, 24'sd0, 24'sd0);
        add_beat(CMD_VERT, 6'd1, 6'd0, H_MIN, H_MAX, 24'sd0, 24'sd0);
        add_beat(CMD_CORNER, 6'd63, 6'd1, H_MAX, H_MIN, H_MIN, H_MAX);
      end
      repeat (PHASE_BEATS) beat_q = {beat_q, random_beat()};
      wait_drained();
    end

    repeat (4 * NSTG) @(posedge clk);
    if (err_count == 0 && height_q.size() == 0) begin
      $display("cosine_seam_blend_test OK");
    end else begin
      $display("cosine_seam_blend_test NOT OK");
    end
    $finish;
  end

endmodule
